// ===== hw/rtl/rlsi_pkg.sv =====
// Package for the run-length skip iterator.
// Holds request action codes, field widths and the controller/datapath interface structs.
// No dependencies.
package rlsi_pkg;

	// Field widths fixed by the request and result formats
	localparam int ACTION_W = 2;
	localparam int COUNT_W  = 32;
	localparam int VALUE_W  = 32;
	localparam int AMOUNT_W = 32;

	// Default table geometry
	localparam int DEF_MAX_PAIRS  = 256;
	localparam int DEF_DATA_WIDTH = 32;

	// Request action codes (code 3 is unused and ignored)
	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_APPEND  = 2'd1,
		ACT_CONSUME = 2'd2
	} action_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;        // empty table, rewind position
		logic append;       // store one pair (dropped when full)
		logic take;         // latch consume amount
		logic advance;      // skip current run: n -= count, position++
		logic stage_empty;  // mark exhausted, stage a not-found result
		logic hit;          // decrement current run, stage a found result
		logic emit;         // move staged result into output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic exhausted;    // sticky end-of-sequence flag
		logic at_end;       // position past last loaded pair
		logic next_at_end;  // position + 1 past last loaded pair
		logic skip;         // remaining amount exceeds current run count
		logic out_free;     // output register can take a result this cycle
	} status_t;

endpackage

// ===== hw/rtl/run_length_skip_iterator.sv =====
// Run-length skip iterator: a table of up to MAX_PAIRS (count, value) runs and a read
// position. Clear and append requests give no result; an append to a full table is
// dropped. A consume request of amount n latches n and then walks the runs it skips:
// the walk inspects one table entry per cycle through the count table's registered
// read port. A walk that runs off the end of the table, or a consume that finds the
// sequence already exhausted or the position at the end of the table, stages a
// not-found result. The emit step that moves a staged result out waits while the output
// register still holds a result that has not been taken. Each consume gives one result
// (found, element_value); element_value is zero when found is 0, and found stays 0 until
// the next clear. A finished result waits in an output register, so clear and append
// requests are still taken while it is pending.
// Depends on rlsi_pkg, rlsi_ctrl, rlsi_datapath, rlsi_ram.
module run_length_skip_iterator #(
	parameter int MAX_PAIRS  = rlsi_pkg::DEF_MAX_PAIRS,
	parameter int DATA_WIDTH = rlsi_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rlsi_pkg::ACTION_W-1:0] action,
	input  logic [rlsi_pkg::COUNT_W-1:0]  run_count,
	input  logic [rlsi_pkg::VALUE_W-1:0]  run_value,
	input  logic [rlsi_pkg::AMOUNT_W-1:0] amount,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [rlsi_pkg::VALUE_W-1:0]  element_value
);
	import rlsi_pkg::*;

	cmd_t    cmd;
	status_t status;

	rlsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.status   (status),
		.cmd      (cmd)
	);

	rlsi_datapath #(
		.MAX_PAIRS  (MAX_PAIRS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.run_count     (run_count),
		.run_value     (run_value),
		.amount        (amount),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.element_value (element_value)
	);

	// A not-found result always carries a zero value
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> element_value == '0)
		else $error("not-found result with nonzero value");

	// An accepted consume holds off new requests while it walks
	a_consume_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_CONSUME |=> !in_ready)
		else $error("request taken during consume walk");

	// Results only appear from the emit step, never straight from idle
	a_emit_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised outside emit step");

endmodule

// ===== hw/rtl/rlsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the run count and run value tables. No dependencies.
module rlsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hw/rtl/rlsi_ctrl.sv =====
// Controller state machine for the run-length skip iterator.
// Sequences clear, append and the consume walk; depends on rlsi_pkg.
module rlsi_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rlsi_pkg::ACTION_W-1:0] action,
	input  rlsi_pkg::status_t             status,
	output rlsi_pkg::cmd_t                cmd
);
	import rlsi_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_next;

	// Next state and command decode
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (action)
						ACT_CLEAR: begin
							cmd.clear = 1'b1;
						end
						ACT_APPEND: begin
							cmd.append = 1'b1;
						end
						ACT_CONSUME: begin
							cmd.take = 1'b1;
							if (status.exhausted || status.at_end) begin
								cmd.stage_empty = 1'b1;
								state_next      = ST_EMIT;
							end else begin
								state_next = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (status.skip) begin
					cmd.advance = 1'b1;
					if (status.next_at_end) begin
						cmd.stage_empty = 1'b1;
						state_next      = ST_EMIT;
					end
				end else begin
					cmd.hit    = 1'b1;
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== hw/rtl/rlsi_datapath.sv =====
// Datapath for the run-length skip iterator: run tables, position and fill
// counters, walk arithmetic and output register. Depends on rlsi_pkg, rlsi_ram.
module rlsi_datapath #(
	parameter int MAX_PAIRS  = rlsi_pkg::DEF_MAX_PAIRS,
	parameter int DATA_WIDTH = rlsi_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlsi_pkg::cmd_t                cmd,
	output rlsi_pkg::status_t             status,
	input  logic [rlsi_pkg::COUNT_W-1:0]  run_count,
	input  logic [rlsi_pkg::VALUE_W-1:0]  run_value,
	input  logic [rlsi_pkg::AMOUNT_W-1:0] amount,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [rlsi_pkg::VALUE_W-1:0]  element_value
);
	import rlsi_pkg::*;

	localparam int AW = $clog2(MAX_PAIRS);
	localparam int CW = $clog2(MAX_PAIRS + 1);

	logic [CW-1:0]         pairs_q;
	logic [CW-1:0]         pos_q;
	logic [CW-1:0]         pos_inc;
	logic                  exh_q;
	logic [AMOUNT_W-1:0]   n_q;
	logic                  res_found_q;
	logic [VALUE_W-1:0]    res_value_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic [VALUE_W-1:0]    value_q;
	logic                  full;
	logic                  store;
	logic                  out_free;
	logic [COUNT_W-1:0]    cnt_rd;
	logic [DATA_WIDTH-1:0] val_rd;
	logic [DATA_WIDTH-1:0] val_wr;
	logic [VALUE_W-1:0]    val_out;
	logic                  cnt_we;
	logic [AW-1:0]         cnt_waddr;
	logic [COUNT_W-1:0]    cnt_wdata;
	logic [AW-1:0]         rd_addr;

	assign full     = (pairs_q == CW'(MAX_PAIRS));
	assign store    = cmd.append && !full;
	assign pos_inc  = pos_q + 1'b1;
	assign out_free = !out_valid_q || out_ready;

	// Value width conversion between ports and table
	if (DATA_WIDTH >= VALUE_W) begin : g_wide
		assign val_wr  = DATA_WIDTH'(run_value);
		assign val_out = val_rd[VALUE_W-1:0];
	end else begin : g_narrow
		assign val_wr  = run_value[DATA_WIDTH-1:0];
		assign val_out = {{(VALUE_W - DATA_WIDTH){1'b0}}, val_rd};
	end

	// Table read follows the position the walk is about to inspect
	assign rd_addr = cmd.advance ? pos_inc[AW-1:0] : pos_q[AW-1:0];

	// Count table is written by append and by the final decrement of a consume
	always_comb begin
		cnt_we    = store || cmd.hit;
		cnt_waddr = pairs_q[AW-1:0];
		cnt_wdata = run_count;
		if (cmd.hit) begin
			cnt_waddr = pos_q[AW-1:0];
			cnt_wdata = cnt_rd - n_q;
		end
	end

	rlsi_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (MAX_PAIRS)
	) u_count_ram (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (cnt_waddr),
		.wr_data (cnt_wdata),
		.rd_addr (rd_addr),
		.rd_data (cnt_rd)
	);

	rlsi_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_PAIRS)
	) u_value_ram (
		.clk     (clk),
		.wr_en   (store),
		.wr_addr (pairs_q[AW-1:0]),
		.wr_data (val_wr),
		.rd_addr (rd_addr),
		.rd_data (val_rd)
	);

	// Status to controller
	assign status.exhausted   = exh_q;
	assign status.at_end      = (pos_q >= pairs_q);
	assign status.next_at_end = (pos_inc >= pairs_q);
	assign status.skip        = (n_q > cnt_rd);
	assign status.out_free    = out_free;

	// Control state: fill count, position, exhausted flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q     <= '0;
			pos_q       <= '0;
			exh_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				pairs_q <= '0;
				pos_q   <= '0;
				exh_q   <= 1'b0;
			end
			if (store) begin
				pairs_q <= pairs_q + 1'b1;
			end
			if (cmd.advance) begin
				pos_q <= pos_inc;
			end
			if (cmd.stage_empty) begin
				exh_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: remaining amount, staged result, output register
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			n_q <= amount;
		end else if (cmd.advance) begin
			n_q <= n_q - cnt_rd;
		end
		if (cmd.stage_empty) begin
			res_found_q <= 1'b0;
			res_value_q <= '0;
		end else if (cmd.hit) begin
			res_found_q <= 1'b1;
			res_value_q <= val_out;
		end
		if (cmd.emit) begin
			found_q <= res_found_q;
			value_q <= res_value_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign element_value = value_q;

endmodule

// ===== bench/tb_run_length_skip_iterator.sv =====
// Testbench for run_length_skip_iterator: directed and random clear/append/consume requests.
// It checks every consume result against an in-bench run-length table tracker.
// Depends on rlsi_pkg and the run_length_skip_iterator RTL.
`timescale 1ns / 1ps

module tb_run_length_skip_iterator;
	import rlsi_pkg::*;

	localparam int TABLE_DEPTH = DEF_MAX_PAIRS;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int TOTAL_REQUESTS = 1350;
	// worst consume walks the whole table, plus overhead
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [COUNT_W-1:0]  cnt;
		logic [VALUE_W-1:0]  val;
		logic [AMOUNT_W-1:0] amt;
	} rle_req_t;

	typedef struct {
		logic               hit;
		logic [VALUE_W-1:0] sym;
	} lookup_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACTION_W-1:0] action = ACT_CLEAR;
	logic [COUNT_W-1:0]  run_count = '0;
	logic [VALUE_W-1:0]  run_value = '0;
	logic [AMOUNT_W-1:0] amount = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                found;
	logic [VALUE_W-1:0]  element_value;

	rle_req_t rle_requests[$];
	lookup_t  expected_lookups[$];
	lookup_t  want;
	int       n_errors = 0;
	int       n_accepted = 0;
	int       n_queued = 0;
	logic     in_taken = 1'b0;

	// tracker copy of the run table
	logic [COUNT_W-1:0] run_left[TABLE_DEPTH];
	logic [VALUE_W-1:0] run_sym[TABLE_DEPTH];
	int unsigned        n_pairs = 0;
	int unsigned        rd_pos = 0;
	logic               seq_done = 1'b0;

	run_length_skip_iterator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.run_count     (run_count),
		.run_value     (run_value),
		.amount        (amount),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.element_value (element_value)
	);

	always #4 clk = ~clk;

	// Apply one accepted request to the tracker; consumes queue their lookup result
	function automatic void rle_track(input logic [ACTION_W-1:0] act,
		input logic [COUNT_W-1:0] cnt, input logic [VALUE_W-1:0] val,
		input logic [AMOUNT_W-1:0] amt);
		logic [AMOUNT_W-1:0] n;
		lookup_t             res;
		n = amt;
		case (act)
			ACT_CLEAR: begin
				n_pairs = 0;
				rd_pos = 0;
				seq_done = 1'b0;
			end
			ACT_APPEND: begin
				// full table drops the pair
				if (n_pairs < TABLE_DEPTH) begin
					run_left[n_pairs] = cnt;
					run_sym[n_pairs] = val;
					n_pairs++;
				end
			end
			ACT_CONSUME: begin
				if (!seq_done) begin
					// skip whole runs while the amount exceeds what is left of them
					while (rd_pos < n_pairs && n > run_left[rd_pos]) begin
						n -= run_left[rd_pos];
						rd_pos++;
					end
					if (rd_pos >= n_pairs)
						seq_done = 1'b1;
				end
				if (seq_done) begin
					res.hit = 1'b0;
					res.sym = '0;
				end else begin
					run_left[rd_pos] -= n;
					res.hit = 1'b1;
					res.sym = run_sym[rd_pos];
				end
				expected_lookups.insert(expected_lookups.size(), res);
			end
			default: ;
		endcase
	endfunction

	task automatic push_req(input logic [ACTION_W-1:0] act, input logic [COUNT_W-1:0] cnt,
		input logic [VALUE_W-1:0] val, input logic [AMOUNT_W-1:0] amt);
		rle_req_t req;
		req.act = act;
		req.cnt = cnt;
		req.val = val;
		req.amt = amt;
		rle_requests.insert(rle_requests.size(), req);
		if (act != ACT_UNUSED)
			n_queued++;
	endtask

	// Run lengths: mostly short, with zero, wide and all-ones counts mixed in
	function automatic logic [COUNT_W-1:0] rand_count();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r <= 5)
			return $urandom_range(1, 6);
		if (r <= 7)
			return $urandom_range(0, 100);
		if (r == 8)
			return $urandom;
		return '1;
	endfunction

	function automatic logic [AMOUNT_W-1:0] rand_amount();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r <= 6)
			return $urandom_range(0, 10);
		if (r == 7)
			return $urandom_range(0, 300);
		if (r == 8)
			return $urandom;
		return '1;
	endfunction

	// Request driver: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	rle_req_t drv_req;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (rle_requests.size() != 0) begin
				drv_req = rle_requests.pop_front();
				action <= drv_req.act;
				run_count <= drv_req.cnt;
				run_value <= drv_req.val;
				amount <= drv_req.amt;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall pattern follows rx_cycle[9:7], plus two long hold-offs
	int rx_cycle = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle == 1500 || rx_cycle == 6000)
				hold_left = 600;
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_cycle[9:7])
					3'd0, 3'd1: out_ready <= 1'b1;
					3'd5:       out_ready <= ($urandom_range(0, 3) == 0);
					3'd6:       out_ready <= (rx_cycle[2:0] != 3'd0);
					3'd7:       out_ready <= rx_cycle[0];
					default:    out_ready <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	// Monitor: check results in order, feed accepted requests to the tracker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_lookups.size() == 0) begin
					n_errors++;
					if (n_errors < 30)
						$display("%0t: result with none pending: found=%0b element_value=%08h",
							$time, found, element_value);
				end else begin
					want = expected_lookups.pop_front();
					if (found !== want.hit) begin
						n_errors++;
						if (n_errors < 30)
							$display("%0t: found mismatch: expected %0b, actual %0b",
								$time, want.hit, found);
					end
					if (element_value !== want.sym) begin
						n_errors++;
						if (n_errors < 30)
							$display("%0t: element_value mismatch: expected %08h, actual %08h",
								$time, want.sym, element_value);
					end
				end
			end
			if (in_valid && in_ready) begin
				rle_track(action, run_count, run_value, amount);
				n_accepted++;
			end
		end
	end

	// Stimulus, reset and end of run
	int session;
	int kind;
	int n_app;
	int n_con;
	int big_done;
	int k;
	int j;
	initial begin
		// Directed: exhaustion, zero-count runs, zero and all-ones amounts
		push_req(ACT_CONSUME, $urandom, $urandom, '0);           // empty table
		push_req(ACT_APPEND, 32'd5, 32'hFFFF_FFFF, $urandom);     // append after exhaustion
		push_req(ACT_CONSUME, $urandom, $urandom, '0);           // still not found
		push_req(ACT_CLEAR, $urandom, $urandom, $urandom);
		push_req(ACT_APPEND, 32'd3, 32'hA5A5_A5A5, $urandom);
		push_req(ACT_APPEND, 32'd0, 32'h0000_0000, $urandom);     // zero-count run
		push_req(ACT_APPEND, 32'hFFFF_FFFF, 32'h5A5A_5A5A, $urandom);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd0);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd2);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd1);         // run drained to zero
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd0);         // zero amount on empty run
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd1);         // skips two runs
		push_req(ACT_CONSUME, $urandom, $urandom, 32'hFFFF_FFFE);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd1);         // runs off the end
		push_req(ACT_UNUSED, $urandom, $urandom, $urandom);      // ignored
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd0);
		push_req(ACT_CLEAR, $urandom, $urandom, $urandom);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'hFFFF_FFFF);
		push_req(ACT_CLEAR, $urandom, $urandom, $urandom);
		push_req(ACT_APPEND, 32'hFFFF_FFFF, 32'h1234_5678, $urandom);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'hFFFF_FFFF);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd0);
		push_req(ACT_CONSUME, $urandom, $urandom, 32'd1);

		// Random sessions: mostly clear/append/consume sequences, some noise
		session = 0;
		big_done = 0;
		while (n_queued < TOTAL_REQUESTS) begin
			kind = $urandom_range(0, 99);
			if (session == 3 || (kind < 2 && big_done < 2)) begin
				// overfill the table, walk it, then run off its end
				big_done++;
				push_req(ACT_CLEAR, $urandom, $urandom, $urandom);
				n_app = TABLE_DEPTH + $urandom_range(1, 6);
				for (k = 0; k < n_app; k++)
					push_req(ACT_APPEND, $urandom_range(0, 3), $urandom, $urandom);
				for (k = 0; k < 30; k++)
					push_req(ACT_CONSUME, $urandom, $urandom, $urandom_range(0, 6));
				push_req(ACT_CONSUME, $urandom, $urandom, '1);
				push_req(ACT_APPEND, rand_count(), $urandom, $urandom);
				push_req(ACT_CONSUME, $urandom, $urandom, '0);
			end else if (kind < 85) begin
				if ($urandom_range(0, 5) != 0)
					push_req(ACT_CLEAR, $urandom, $urandom, $urandom);
				n_app = $urandom_range(1, 12);
				n_con = $urandom_range(1, 16);
				for (k = 0; k < n_app; k++)
					push_req(ACT_APPEND, rand_count(), $urandom, $urandom);
				for (j = 0; j < n_con; j++) begin
					if ($urandom_range(0, 7) == 0)
						push_req(ACT_APPEND, rand_count(), $urandom, $urandom);
					if ($urandom_range(0, 9) == 0)
						push_req(ACT_UNUSED, $urandom, $urandom, $urandom);
					push_req(ACT_CONSUME, $urandom, $urandom, rand_amount());
				end
			end else begin
				n_app = $urandom_range(1, 6);
				for (k = 0; k < n_app; k++)
					push_req(ACTION_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
			end
			session++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every request to be taken and every result to arrive
		while (n_accepted < n_queued || rle_requests.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_lookups.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
